// File: hw/rtl/acd_pkg.sv
`timescale 1ns / 1ps
package acd_pkg;

   // Field widths of the channels
   localparam int SAMPLE_W    = 16;
   localparam int POS_OUT_W   = 40;
   localparam int CNT_OUT_W   = 32;
   localparam int THRESH_W    = 16;

   // Default state widths
   localparam int DEFAULT_POSITION_BITS = 40;
   localparam int DEFAULT_COUNT_BITS    = 32;

   // Register port geometry: four registers, 8 bytes apart
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_LSB     = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CLIP_LEVEL      = 2'd0,
      REG_START_THRESHOLD = 2'd1,
      REG_STOP_THRESHOLD  = 2'd2,
      REG_START_POSITION  = 2'd3
   } reg_index_type;

   // Register reset values
   localparam logic [THRESH_W-1:0]  CLIP_LEVEL_RST      = 16'd32767;
   localparam logic [THRESH_W-1:0]  START_THRESHOLD_RST = 16'd3;
   localparam logic [THRESH_W-1:0]  STOP_THRESHOLD_RST  = 16'd3;
   localparam logic [POS_OUT_W-1:0] START_POSITION_RST  = 40'd0;

   typedef struct packed {
      logic [THRESH_W-1:0]  clip_level;
      logic [THRESH_W-1:0]  start_threshold;
      logic [THRESH_W-1:0]  stop_threshold;
      logic [POS_OUT_W-1:0] start_position;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       channel_start;
   } item_type;

endpackage

// File: hw/rtl/acd_if.sv
`timescale 1ns / 1ps
interface acd_req_if import acd_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       channel_start;

   modport source (output valid, output sample, output channel_start, input ready);
   modport sink (input valid, input sample, input channel_start, output ready);
endinterface

interface acd_rsp_if import acd_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [POS_OUT_W-1:0] run_begin;
   logic [POS_OUT_W-1:0] run_finish;
   logic [CNT_OUT_W-1:0] clipped_count;
   logic [CNT_OUT_W-1:0] span_count;

   modport source (output valid, output run_begin, output run_finish,
                   output clipped_count, output span_count, input ready);
   modport sink (input valid, input run_begin, input run_finish,
                 input clipped_count, input span_count, output ready);
endinterface

// File: hw/rtl/acd_csr.sv
`timescale 1ns / 1ps
module acd_csr import acd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[CSR_LSB +: CSR_INDEX_W]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_level      <= CLIP_LEVEL_RST;
         cfg_ff.start_threshold <= START_THRESHOLD_RST;
         cfg_ff.stop_threshold  <= STOP_THRESHOLD_RST;
         cfg_ff.start_position  <= START_POSITION_RST;
      end else if (write_en) begin
         unique case (index)
            REG_CLIP_LEVEL:      cfg_ff.clip_level      <= csr_pwdata[THRESH_W-1:0];
            REG_START_THRESHOLD: cfg_ff.start_threshold <= csr_pwdata[THRESH_W-1:0];
            REG_STOP_THRESHOLD:  cfg_ff.stop_threshold  <= csr_pwdata[THRESH_W-1:0];
            REG_START_POSITION:  cfg_ff.start_position  <= csr_pwdata[POS_OUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         REG_CLIP_LEVEL:      csr_prdata = CSR_DATA_W'(cfg_ff.clip_level);
         REG_START_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.start_threshold);
         REG_STOP_THRESHOLD:  csr_prdata = CSR_DATA_W'(cfg_ff.stop_threshold);
         REG_START_POSITION:  csr_prdata = CSR_DATA_W'(cfg_ff.start_position);
         default:             csr_prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/acd_in_stage.sv
`timescale 1ns / 1ps
module acd_in_stage import acd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [SAMPLE_W-1:0] in_sample,
   input  logic                       in_channel_start,
   output logic                       in_ready,
   input  logic                       advance,
   output item_type                   item
);

   logic                       valid_ff;
   logic                       valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       chan_ff;
   logic                       load;

   // Take a new item when the register is empty or moves on this cycle
   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the item moves on
   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= in_sample;
         chan_ff   <= in_channel_start;
      end
   end

   assign item.valid         = valid_ff;
   assign item.sample        = sample_ff;
   assign item.channel_start = chan_ff;

endmodule

// File: hw/rtl/acd_core.sv
`timescale 1ns / 1ps
module acd_core import acd_pkg::*; #(
   parameter int POSITION_BITS = DEFAULT_POSITION_BITS,
   parameter int COUNT_BITS    = DEFAULT_COUNT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  item_type             item,
   input  cfg_type              cfg,
   output logic                 advance,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [POS_OUT_W-1:0] out_run_begin,
   output logic [POS_OUT_W-1:0] out_run_finish,
   output logic [CNT_OUT_W-1:0] out_clipped_count,
   output logic [CNT_OUT_W-1:0] out_span_count
);

   localparam int MAG_W = SAMPLE_W + 1;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Run state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] origin_ff, origin_in;
   logic [COUNT_BITS-1:0]    run_ff, run_in;
   logic [COUNT_BITS-1:0]    quiet_ff, quiet_in;
   logic [COUNT_BITS-1:0]    span_ff, span_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_OUT_W-1:0] begin_ff;
   logic [POS_OUT_W-1:0] finish_ff;
   logic [CNT_OUT_W-1:0] clipped_ff;
   logic [CNT_OUT_W-1:0] spanc_ff;

   // Working values
   logic [POSITION_BITS-1:0] pos_cur, origin_cur;
   logic [COUNT_BITS-1:0]    run_cur, quiet_cur, span_cur;
   logic [MAG_W-1:0]         raw, mag;
   logic                     clipped;
   logic [COUNT_BITS-1:0]    start_thr, stop_thr;
   logic [COUNT_BITS-1:0]    quiet_inc, span_inc, span_base;
   logic                     emit;
   logic [COUNT_BITS-1:0]    span_out;
   logic                     step;

   assign advance = !rsp_valid_ff || out_ready;
   assign step    = advance && item.valid;

   // Start of channel clears the run and reloads the position
   always_comb begin
      if (item.channel_start) begin
         pos_cur    = POSITION_BITS'(cfg.start_position);
         origin_cur = '0;
         run_cur    = '0;
         quiet_cur  = '0;
         span_cur   = '0;
      end else begin
         pos_cur    = pos_ff;
         origin_cur = origin_ff;
         run_cur    = run_ff;
         quiet_cur  = quiet_ff;
         span_cur   = span_ff;
      end
   end

   // Magnitude of the sample, 0 to full scale
   assign raw     = MAG_W'(unsigned'(item.sample));
   assign mag     = item.sample[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - raw : raw;
   assign clipped = mag >= MAG_W'(cfg.clip_level);

   assign start_thr = COUNT_BITS'(cfg.start_threshold);
   assign stop_thr  = COUNT_BITS'(cfg.stop_threshold);
   assign quiet_inc = (quiet_cur == CNT_MAX) ? quiet_cur : quiet_cur + 1'b1;
   assign span_inc  = (span_cur == CNT_MAX) ? span_cur : span_cur + 1'b1;
   assign span_base = (run_cur == '0) ? '0 : span_cur;
   assign span_out  = (span_inc >= stop_thr) ? span_inc - stop_thr : '0;

   // Update the run for one sample
   always_comb begin
      origin_in = origin_cur;
      run_in    = run_cur;
      quiet_in  = quiet_cur;
      span_in   = span_cur;
      emit      = 1'b0;
      priority if (clipped) begin
         if (run_cur == '0) begin
            origin_in = pos_cur;
         end else begin
            quiet_in = '0;
         end
         run_in  = (run_cur == CNT_MAX) ? run_cur : run_cur + 1'b1;
         span_in = (span_base == CNT_MAX) ? span_base : span_base + 1'b1;
      end else if (run_cur >= start_thr) begin
         if (quiet_inc >= stop_thr) begin
            emit     = 1'b1;
            run_in   = '0;
            quiet_in = '0;
            span_in  = '0;
         end else begin
            quiet_in = quiet_inc;
            span_in  = span_inc;
         end
      end else begin
         run_in = '0;
      end
   end

   assign pos_in       = pos_cur + 1'b1;
   assign rsp_valid_in = advance ? (item.valid && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         origin_ff    <= '0;
         run_ff       <= '0;
         quiet_ff     <= '0;
         span_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            pos_ff    <= pos_in;
            origin_ff <= origin_in;
            run_ff    <= run_in;
            quiet_ff  <= quiet_in;
            span_ff   <= span_in;
         end
      end
   end

   // Capture the label
   always_ff @(posedge clock) begin
      if (step && emit) begin
         begin_ff   <= POS_OUT_W'(origin_cur);
         finish_ff  <= POS_OUT_W'(pos_cur - POSITION_BITS'(cfg.stop_threshold));
         clipped_ff <= CNT_OUT_W'(run_cur);
         spanc_ff   <= CNT_OUT_W'(span_out);
      end
   end

   assign out_valid         = rsp_valid_ff;
   assign out_run_begin     = begin_ff;
   assign out_run_finish    = finish_ff;
   assign out_clipped_count = clipped_ff;
   assign out_span_count    = spanc_ff;

endmodule

// File: hw/rtl/audio_clipping_run_detector.sv
`timescale 1ns / 1ps
// Audio clipping run detector.
// req_chan carries one signed 16-bit sample per item plus a channel_start
// flag that clears the run state and reloads the position from
// start_position. rsp_chan carries one label per qualified run that ends:
// run begin and finish positions, clipped count and span count.
// Items use valid/ready; an item moves when both are high.
// Throughput: one item per cycle while rsp_chan does not stall. The run
// update between the input and result registers is combinational.
// The sample that ends a run is held in the input register; its label is
// then captured in the result register and shown on rsp_chan.
// The APB-style csr port holds clip_level, start_threshold,
// stop_threshold and start_position at byte addresses 0, 8, 16 and 24;
// pready is always high. Write them only while no item is in flight.
// Reset (synchronous, active high) empties both registers, clears the
// run state and position, and loads the register defaults.
// When rsp_chan stalls, the label holds, the update stops and req_chan
// takes at most one more item into the input register.
module audio_clipping_run_detector import acd_pkg::*; #(
   parameter int POSITION_BITS = DEFAULT_POSITION_BITS,
   parameter int COUNT_BITS    = DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   acd_req_if.sink               req_chan,
   acd_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   item_type item;
   logic     advance;

   acd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   acd_in_stage u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_chan.valid),
      .in_sample        (req_chan.sample),
      .in_channel_start (req_chan.channel_start),
      .in_ready         (req_chan.ready),
      .advance          (advance),
      .item             (item)
   );

   acd_core #(
      .POSITION_BITS (POSITION_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .item              (item),
      .cfg               (cfg),
      .advance           (advance),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_run_begin     (rsp_chan.run_begin),
      .out_run_finish    (rsp_chan.run_finish),
      .out_clipped_count (rsp_chan.clipped_count),
      .out_span_count    (rsp_chan.span_count)
   );

endmodule
